// ----- rtl/spq_pkg.sv -----
// ============================================================================
// spq_pkg
// Shared types and constants for the sorted priority queue: field widths,
// operation codes, status codes and the command that every cell sees.
// ============================================================================
package spq_pkg;

    localparam int DEFAULT_CAPACITY = 64;
    localparam int DATA_W           = 32;
    localparam int OCC_W            = 7;
    localparam int STATUS_W         = 2;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } spq_status_t;

    // Broadcast to every cell of the chain in the cycle a word is accepted.
    typedef struct packed {
        logic                     shift_in;
        logic                     shift_out;
        logic signed [DATA_W-1:0] new_value;
    } spq_cmd_t;

endpackage

// ----- rtl/spq_cell.sv -----
// ============================================================================
// spq_cell
// One storage cell of the sorted chain. Holds one entry, compares it with
// the value being inserted and takes its own, its left or its right
// neighbor's value as the command requires.
// ============================================================================
module spq_cell
    import spq_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int CNT_W = 7
) (
    input  logic                     aclk,
    input  spq_cmd_t                 cmd,
    input  logic [CNT_W-1:0]         count,
    input  logic                     left_keep,
    input  logic signed [DATA_W-1:0] left_value,
    input  logic signed [DATA_W-1:0] right_value,
    output logic                     keep,
    output logic signed [DATA_W-1:0] value
);

    logic signed [DATA_W-1:0] value_reg;
    logic signed [DATA_W-1:0] value_next;
    logic                     occupied;

    assign occupied = (count > CNT_W'(IDX));

    // An occupied entry that is greater than or equal to the new value stays
    // in front of it, so equal values keep their arrival order.
    assign keep = occupied && (value_reg >= cmd.new_value);

    always_comb begin
        value_next = value_reg;
        if (cmd.shift_in) begin
            if (!keep) begin
                value_next = left_keep ? cmd.new_value : left_value;
            end
        end else if (cmd.shift_out) begin
            value_next = right_value;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

// ----- rtl/sorted_priority_queue.sv -----
// ============================================================================
// sorted_priority_queue
// Max-first priority queue built as a systolic chain of sorted cells.
// ============================================================================
// The queue holds up to CAPACITY signed 32-bit entries, largest at the
// front. An insert word places its value behind every stored value that is
// greater than or equal to it, so equal values leave in arrival order; a
// remove word returns the front entry. Each accepted word produces exactly
// one result word carrying the removed value (zero unless a remove
// succeeded), a status (ok, remove on empty, insert on full dropped) and
// the occupancy after the word, reported modulo 128. While the output is
// not stalled the queue takes one word per clock cycle: every cell compares
// its entry with the incoming value in parallel and then keeps its entry,
// takes the new value or takes a neighbor's entry, so the work of one word
// is a single 32-bit compare per cell plus a four-way select. The result
// word is in the output register in the cycle after acceptance. The input
// is taken while the output register is empty or is being emptied in the
// same cycle, so a stalled result holds back at most one further word. Only
// the entry count is reset; entries beyond the count are never read, so no
// clearing pass is needed and the queue accepts words right after reset.
// ============================================================================
module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_operation,
    input  logic signed [DATA_W-1:0] s_value,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [DATA_W-1:0] m_removed_value,
    output logic [STATUS_W-1:0]      m_status,
    output logic [OCC_W-1:0]         m_occupancy
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    logic                     m_valid_reg;
    logic signed [DATA_W-1:0] m_removed_value_reg;
    logic signed [DATA_W-1:0] m_removed_value_next;
    spq_status_t              m_status_reg;
    spq_status_t              m_status_next;
    logic [OCC_W-1:0]         m_occupancy_reg;
    logic [OCC_W-1:0]         m_occupancy_next;

    logic     accept;
    logic     is_full;
    logic     is_empty;
    spq_cmd_t cmd;

    logic signed [DATA_W-1:0] cell_value [CAPACITY];
    logic                     cell_keep  [CAPACITY];

    logic [OCC_W+CNT_W-1:0]   count_wide;

    // The output register is the only buffer: a new word enters when it is
    // empty or when its current word leaves in this cycle.
    assign s_ready  = !m_valid_reg || m_ready;
    assign accept   = s_valid && s_ready;
    assign is_full  = (count_reg == CNT_W'(CAPACITY));
    assign is_empty = (count_reg == '0);

    always_comb begin
        cmd.shift_in  = accept && (s_operation == OP_INSERT) && !is_full;
        cmd.shift_out = accept && (s_operation == OP_REMOVE) && !is_empty;
        cmd.new_value = s_value;
    end

    // Chain of cells. The first cell sees a left neighbor that always keeps
    // its place, so it takes the new value whenever its own entry does not
    // stay in front. The last cell pulls in a don't-care zero on a remove;
    // the count shrinks in the same cycle, so that entry is never read.
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic                     left_keep;
        logic signed [DATA_W-1:0] left_value;
        logic signed [DATA_W-1:0] right_value;

        if (i == 0) begin : g_first
            assign left_keep  = 1'b1;
            assign left_value = s_value;
        end else begin : g_inner
            assign left_keep  = cell_keep[i-1];
            assign left_value = cell_value[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign right_value = '0;
        end else begin : g_body
            assign right_value = cell_value[i+1];
        end

        spq_cell #(
            .IDX   (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .aclk        (aclk),
            .cmd         (cmd),
            .count       (count_reg),
            .left_keep   (left_keep),
            .left_value  (left_value),
            .right_value (right_value),
            .keep        (cell_keep[i]),
            .value       (cell_value[i])
        );
    end

    always_comb begin
        count_next = count_reg;
        if (cmd.shift_in) begin
            count_next = count_reg + CNT_W'(1);
        end else if (cmd.shift_out) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // Occupancy is reported modulo 128, also when the count is narrower.
    assign count_wide = {{OCC_W{1'b0}}, count_next};

    always_comb begin
        m_removed_value_next = '0;
        m_status_next        = STATUS_OK;
        m_occupancy_next     = count_wide[OCC_W-1:0];
        if (s_operation == OP_INSERT) begin
            if (is_full) begin
                m_status_next = STATUS_FULL;
            end
        end else begin
            if (is_empty) begin
                m_status_next = STATUS_EMPTY;
            end else begin
                m_removed_value_next = cell_value[0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_removed_value_reg <= m_removed_value_next;
            m_status_reg        <= m_status_next;
            m_occupancy_reg     <= m_occupancy_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_removed_value = m_removed_value_reg;
    assign m_status        = m_status_reg;
    assign m_occupancy     = m_occupancy_reg;

    // The entry count never runs past the capacity.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count exceeds capacity");

    // A successful insert grows the queue by exactly one entry.
    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.shift_in |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("insert did not grow the queue by one");

    // A remove on an empty queue reports empty with a zero value.
    a_empty_remove: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_operation == OP_REMOVE) && is_empty) |=>
        (m_status_reg == STATUS_EMPTY) && (m_removed_value_reg == '0) && m_valid_reg)
        else $error("remove on empty queue reported wrongly");

    // The two front entries stay in order.
    a_front_sorted: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg >= CNT_W'(2)) |-> (cell_value[0] >= cell_value[1]))
        else $error("front entries out of order");

    // A dropped insert leaves the count unchanged.
    a_full_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_operation == OP_INSERT) && is_full) |=> $stable(count_reg))
        else $error("insert on full queue changed the count");

endmodule
